// ===== hw/rtl/mtfd_pkg.sv =====
// Shared types and constants for the serial frame deframer.
package mtfd_pkg;

   localparam logic [7:0] START_RESET = 8'hFE;
   localparam logic [7:0] TYPE_MASK   = 8'hE0;
   localparam logic [7:0] SUB_MASK    = 8'h1F;

   typedef enum logic [5:0] {
      PH_HUNT  = 6'b000001,
      PH_LEN   = 6'b000010,
      PH_CMD0  = 6'b000100,
      PH_CMD1  = 6'b001000,
      PH_DATA  = 6'b010000,
      PH_CHECK = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic [2:0] frame_type;
      logic [4:0] subsystem;
      logic [7:0] command_id;
      logic [7:0] frame_length;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } result_bus_type;

endpackage

// ===== hw/rtl/mtfd_ifs.sv =====
// Valid/ready channel interfaces for received bytes and deframer results.
interface mtfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mtfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic [7:0] byte_index;
   logic [2:0] frame_type;
   logic [4:0] subsystem;
   logic [7:0] command_id;
   logic [7:0] frame_length;
   modport source (output valid, output kind, output payload_byte, output byte_index,
                   output frame_type, output subsystem, output command_id,
                   output frame_length, input ready);
   modport sink (input valid, input kind, input payload_byte, input byte_index,
                 input frame_type, input subsystem, input command_id,
                 input frame_length, output ready);
endinterface

// ===== hw/rtl/mt_frame_deframer.sv =====
// Serial frame deframer top level: input register, frame parser, result register.
// Takes one received byte per cycle and hunts for the start byte (csr_data written
// through csr_we, 0xFE after reset), then reads length, two command bytes, the payload
// and an XOR check byte. Every payload byte comes out as an item with its index; the
// check byte gives one frame-end item marked good or bad with the header fields. A byte
// is accepted every cycle while the result side keeps up; a result is offered from the
// result register after its byte is accepted: the byte sits in the input register until
// the parser takes it, and the result register loads at that edge. The parser state
// advances once per byte, so back-to-back bytes stall only while a result is held in
// the result register; then the input register fills and ready drops.
module mt_frame_deframer
   import mtfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_data,
   mtfd_req_if.sink    req_chan,
   mtfd_rsp_if.source  rsp_chan
);

   logic           in_valid;
   logic [7:0]     in_byte;
   logic           space;
   logic           drain;
   result_bus_type result;
   result_type     rsp_data;

   assign drain = in_valid && space;

   mtfd_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_byte  (req_chan.rx_byte),
      .req_ready (req_chan.ready),
      .drain     (drain),
      .in_valid  (in_valid),
      .in_byte   (in_byte)
   );

   mtfd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_data (csr_data),
      .step     (drain),
      .rx_byte  (in_byte),
      .result   (result)
   );

   mtfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (result),
      .space     (space),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.kind         = rsp_data.kind;
   assign rsp_chan.payload_byte = rsp_data.payload_byte;
   assign rsp_chan.byte_index   = rsp_data.byte_index;
   assign rsp_chan.frame_type   = rsp_data.frame_type;
   assign rsp_chan.subsystem    = rsp_data.subsystem;
   assign rsp_chan.command_id   = rsp_data.command_id;
   assign rsp_chan.frame_length = rsp_data.frame_length;

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result pending after reset");

   // a full input stage facing a stalled result stage must backpressure
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (in_valid && rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input accepted while pipeline stalled");

   // a result produced by the parser always reaches the result register
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> rsp_chan.valid)
      else $error("parser result dropped");

   // a dropped parser result would show as a stalled result being replaced
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !result.valid)
      else $error("result register overwritten while stalled");

endmodule

// ===== hw/rtl/mtfd_in_stage.sv =====
// Input register: holds one received byte until the parser takes it.
module mtfd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_byte,
   output logic       req_ready,
   input  logic       drain,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign req_ready = !valid_ff || drain;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

// ===== hw/rtl/mtfd_parser.sv =====
// Frame parser: phase state, header capture, running check and result build.
module mtfd_parser
   import mtfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [7:0]     csr_data,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   output result_bus_type result
);

   phase_type  phase_ff, phase_in;
   logic [7:0] start_ff;
   logic [7:0] exp_len_ff, exp_len_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] cmd0_ff, cmd0_in;
   logic [7:0] cmd1_ff, cmd1_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] count_inc;
   logic [7:0] type_bits;

   assign count_inc = count_ff + 8'd1;
   assign type_bits = cmd0_ff & TYPE_MASK;

   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      count_in   = count_ff;
      cmd0_in    = cmd0_ff;
      cmd1_in    = cmd1_ff;
      check_in   = check_ff;
      result     = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == start_ff) phase_in = PH_LEN;
         end
         PH_LEN: begin
            exp_len_in = rx_byte;
            count_in   = 8'd0;
            check_in   = rx_byte;
            phase_in   = PH_CMD0;
         end
         PH_CMD0: begin
            cmd0_in  = rx_byte;
            check_in = check_ff ^ rx_byte;
            phase_in = PH_CMD1;
         end
         PH_CMD1: begin
            cmd1_in  = rx_byte;
            check_in = check_ff ^ rx_byte;
            // zero length skips straight to the check byte
            phase_in = (exp_len_ff != 8'd0) ? PH_DATA : PH_CHECK;
         end
         PH_DATA: begin
            result.valid             = 1'b1;
            result.data.kind         = KIND_PAYLOAD;
            result.data.payload_byte = rx_byte;
            result.data.byte_index   = count_ff;
            check_in = check_ff ^ rx_byte;
            count_in = count_inc;
            if (count_inc >= exp_len_ff) phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            result.valid             = 1'b1;
            result.data.kind         = (rx_byte == check_ff) ? KIND_GOOD : KIND_BAD;
            result.data.frame_type   = type_bits[7:5];
            result.data.subsystem    = cmd0_ff[4:0] & SUB_MASK[4:0];
            result.data.command_id   = cmd1_ff;
            result.data.frame_length = exp_len_ff;
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      if (!step) result.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         start_ff   <= START_RESET;
         exp_len_ff <= 8'd0;
         count_ff   <= 8'd0;
         cmd0_ff    <= 8'd0;
         cmd1_ff    <= 8'd0;
         check_ff   <= 8'd0;
      end else begin
         if (csr_we) start_ff <= csr_data;
         if (step) begin
            phase_ff   <= phase_in;
            exp_len_ff <= exp_len_in;
            count_ff   <= count_in;
            cmd0_ff    <= cmd0_in;
            cmd1_ff    <= cmd1_in;
            check_ff   <= check_in;
         end
      end
   end

endmodule

// ===== hw/rtl/mtfd_out_stage.sv =====
// Result register: holds one result item until the consumer takes it.
module mtfd_out_stage
   import mtfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  result_bus_type load,
   output logic           space,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output result_type     rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load.valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         data_ff <= load.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
